// ===== hdl/pclg_pkg.sv =====
// Shared types and constants for the peak compressor/limiter gain unit.
// Used by the controller, the datapath and the top level; no dependencies.
package pclg_pkg;

    localparam int LEVEL_FRAC_BITS = 15;
    localparam int STEP_FRAC_BITS  = 20;

    localparam int LEVEL_W    = 16;
    localparam int STEP_W     = 20;
    localparam int RATE_W     = 31;
    localparam int PROD_W     = RATE_W + STEP_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam int DIV_STEPS = LEVEL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] GAIN_ONE  = LEVEL_W'(1 << LEVEL_FRAC_BITS);
    localparam logic [LEVEL_W-1:0] RATIO_ONE = LEVEL_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_RATIO     = 3'd1,
        CFG_CEILING   = 3'd2,
        CFG_ATTACK    = 3'd3,
        CFG_RELEASE   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic div_step;
        logic load2;
        logic finish;
        logic mul;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic bypass;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/pclg_ctrl.sv =====
// Sequencing state machine for the gain unit.
// Depends on pclg_pkg for the command and status structs.
module pclg_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pclg_pkg::status_t status,
    output pclg_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PREP  = 8'b0000_0010,
        ST_DIV1  = 8'b0000_0100,
        ST_LOAD2 = 8'b0000_1000,
        ST_DIV2  = 8'b0001_0000,
        ST_FIN   = 8'b0010_0000,
        ST_MUL   = 8'b0100_0000,
        ST_SLEW  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = status.bypass ? ST_MUL : ST_DIV1;
            end
            ST_DIV1: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_LOAD2;
                end
            end
            ST_LOAD2: begin
                cmd.load2  = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SLEW;
            end
            ST_SLEW: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/pclg_dp.sv =====
// Datapath: configuration registers, shared restoring divider, slew multiplier,
// held gain and output register. Depends on pclg_pkg.
module pclg_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [pclg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pclg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [pclg_pkg::LEVEL_W-1:0]        in_level,
    input  logic [pclg_pkg::STEP_W-1:0]         in_step,
    input  pclg_pkg::cmd_t                      cmd,
    output pclg_pkg::status_t                   status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pclg_pkg::LEVEL_W-1:0]        out_current,
    output logic [pclg_pkg::LEVEL_W-1:0]        out_target
);

    localparam int LW = pclg_pkg::LEVEL_W;
    localparam int HALF = LW / 2;

    logic [LW-1:0]                    thr_cfg_reg;
    logic [LW-1:0]                    ratio_cfg_reg;
    logic [LW-1:0]                    ceil_cfg_reg;
    logic [pclg_pkg::RATE_W-1:0]      attack_reg;
    logic [pclg_pkg::RATE_W-1:0]      release_reg;
    logic [LW-1:0]                    held_reg;
    logic [LW-1:0]                    held_next;
    logic                             out_valid_reg;
    logic [pclg_pkg::CNT_W-1:0]       cnt_reg;

    logic [LW-1:0]                    level_reg;
    logic [pclg_pkg::STEP_W-1:0]      step_reg;
    logic [LW-1:0]                    rem_reg;
    logic [LW-1:0]                    num_reg;
    logic [LW-1:0]                    quo_reg;
    logic [LW-1:0]                    divisor_reg;
    logic [LW-1:0]                    target_reg;
    logic [pclg_pkg::PROD_W-1:0]      prod_reg;
    logic [pclg_pkg::PROD_W-1:0]      prod_next;
    logic [LW-1:0]                    out_cur_reg;
    logic [LW-1:0]                    out_tgt_reg;

    logic [LW-1:0]                    thr;
    logic [LW-1:0]                    ceil_clamped;
    logic [LW-1:0]                    ceil_eff;
    logic [LW-1:0]                    ratio_eff;
    logic [LW-1:0]                    excess;
    logic [LW:0]                      rem_shift;
    logic [LW:0]                      rem_sub;
    logic                             fits;
    logic [LW-1:0]                    rem_step;
    logic [LW:0]                      allowed_sum;
    logic [LW-1:0]                    allowed;
    logic [LW-1:0]                    target_fin;
    logic [pclg_pkg::RATE_W-1:0]      rate_sel;
    logic [pclg_pkg::RATE_W-1:0]      delta;
    logic [LW-1:0]                    diff_dn;
    logic [LW-1:0]                    diff_up;

    always_comb begin
        thr          = (thr_cfg_reg > pclg_pkg::GAIN_ONE) ? pclg_pkg::GAIN_ONE : thr_cfg_reg;
        ceil_clamped = (ceil_cfg_reg > pclg_pkg::GAIN_ONE) ? pclg_pkg::GAIN_ONE : ceil_cfg_reg;
        ceil_eff     = (ceil_clamped < thr) ? thr : ceil_clamped;
        ratio_eff    = (ratio_cfg_reg < pclg_pkg::RATIO_ONE) ? pclg_pkg::RATIO_ONE
                                                            : ratio_cfg_reg;
        excess       = level_reg - thr;

        rem_shift = {rem_reg, num_reg[LW-1]};
        fits      = (rem_shift >= {1'b0, divisor_reg});
        rem_sub   = rem_shift - {1'b0, divisor_reg};
        rem_step  = fits ? rem_sub[LW-1:0] : rem_shift[LW-1:0];

        allowed_sum = {1'b0, thr} + {1'b0, quo_reg};
        allowed     = (allowed_sum > {1'b0, ceil_eff}) ? ceil_eff : allowed_sum[LW-1:0];
        target_fin  = (quo_reg > pclg_pkg::GAIN_ONE) ? pclg_pkg::GAIN_ONE : quo_reg;

        rate_sel  = (held_reg > target_reg) ? attack_reg : release_reg;
        prod_next = {{pclg_pkg::STEP_W{1'b0}}, rate_sel}
                  * {{pclg_pkg::RATE_W{1'b0}}, step_reg};

        delta   = prod_reg[pclg_pkg::PROD_W-1:pclg_pkg::STEP_FRAC_BITS];
        diff_dn = held_reg - target_reg;
        diff_up = target_reg - held_reg;

        held_next = held_reg;
        if (step_reg != '0) begin
            if (held_reg > target_reg) begin
                held_next = (delta >= {{(pclg_pkg::RATE_W-LW){1'b0}}, diff_dn})
                          ? target_reg : held_reg - delta[LW-1:0];
            end else if (held_reg < target_reg) begin
                held_next = (delta >= {{(pclg_pkg::RATE_W-LW){1'b0}}, diff_up})
                          ? target_reg : held_reg + delta[LW-1:0];
            end
        end
    end

    assign status.bypass   = (level_reg == '0) || (level_reg <= thr);
    assign status.div_last = (cnt_reg == pclg_pkg::CNT_W'(pclg_pkg::DIV_STEPS - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_current = out_cur_reg;
    assign out_target  = out_tgt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_cfg_reg   <= pclg_pkg::GAIN_ONE;
            ratio_cfg_reg <= pclg_pkg::RATIO_ONE;
            ceil_cfg_reg  <= pclg_pkg::GAIN_ONE;
            attack_reg    <= '0;
            release_reg   <= '0;
            held_reg      <= pclg_pkg::GAIN_ONE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    pclg_pkg::CFG_THRESHOLD: thr_cfg_reg   <= cfg_data[LW-1:0];
                    pclg_pkg::CFG_RATIO:     ratio_cfg_reg <= cfg_data[LW-1:0];
                    pclg_pkg::CFG_CEILING:   ceil_cfg_reg  <= cfg_data[LW-1:0];
                    pclg_pkg::CFG_ATTACK:    attack_reg    <= cfg_data[pclg_pkg::RATE_W-1:0];
                    pclg_pkg::CFG_RELEASE:   release_reg   <= cfg_data[pclg_pkg::RATE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.prep || cmd.load2) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.commit) begin
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            level_reg <= in_level;
            step_reg  <= in_step;
        end
        if (cmd.prep) begin
            if (status.bypass) begin
                target_reg <= pclg_pkg::GAIN_ONE;
            end else begin
                rem_reg     <= {{HALF{1'b0}}, excess[LW-1:HALF]};
                num_reg     <= {excess[HALF-1:0], {HALF{1'b0}}};
                divisor_reg <= ratio_eff;
                quo_reg     <= '0;
            end
        end
        if (cmd.div_step) begin
            rem_reg <= rem_step;
            num_reg <= {num_reg[LW-2:0], 1'b0};
            quo_reg <= {quo_reg[LW-2:0], fits};
        end
        if (cmd.load2) begin
            rem_reg     <= {1'b0, allowed[LW-1:1]};
            num_reg     <= {allowed[0], {(LW-1){1'b0}}};
            divisor_reg <= level_reg;
            quo_reg     <= '0;
        end
        if (cmd.finish) begin
            target_reg <= target_fin;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.commit) begin
            out_cur_reg <= held_next;
            out_tgt_reg <= target_reg;
        end
    end

endmodule

// ===== hdl/peak_compressor_limiter_gain_unit.sv =====
// A word above the knee passes through prep, a 16-step restoring division, a reload,
// a second division on the same divider, finish, multiply and slew before m_tvalid
// rises; a zero level or one at or below the knee goes from prep to multiply. One word
// in flight; the commit waits while an earlier result still waits for m_tready.
// Reset (synchronous, aresetn low) restores unity gain and the default registers.
// Top level of the peak compressor/limiter gain unit; instantiates pclg_ctrl and pclg_dp.
module peak_compressor_limiter_gain_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // peak_level [15:0], time_step [35:16], zero fill [39:36]
    input  logic [39:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // current_gain [15:0], target_gain [31:16]
    output logic [31:0]                     m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pclg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pclg_pkg::CFG_DATA_W-1:0] cfg_data
);

    pclg_pkg::cmd_t    cmd;
    pclg_pkg::status_t status;
    logic [pclg_pkg::LEVEL_W-1:0] out_current;
    logic [pclg_pkg::LEVEL_W-1:0] out_target;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {out_target, out_current};

    pclg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pclg_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_level    (s_tdata[15:0]),
        .in_step     (s_tdata[35:16]),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_current (out_current),
        .out_target  (out_target)
    );

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.prep)
        else $error("Accepted word did not start the computation.");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("Result overwrote an untaken word.");

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("More than one datapath command at once.");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_current <= pclg_pkg::GAIN_ONE && out_target <= pclg_pkg::GAIN_ONE))
        else $error("Gain above unity.");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for peak_compressor_limiter_gain_unit: directed and random words
// are checked against a scoreboard class that predicts the knee curve and the slewed gain.
// Depends on pclg_pkg and the gain unit RTL only.
module tb;

    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_WORDS = 225;
    localparam int          MAX_PRINTS = 100;
    localparam logic [63:0] UNITY = 64'd1 << pclg_pkg::LEVEL_FRAC_BITS;

    typedef struct packed {
        logic [pclg_pkg::LEVEL_W-1:0] target;
        logic [pclg_pkg::LEVEL_W-1:0] gain;
    } gain_result_t;

    class gain_scoreboard;
        logic [pclg_pkg::LEVEL_W-1:0] thr_reg;
        logic [pclg_pkg::LEVEL_W-1:0] ratio_reg;
        logic [pclg_pkg::LEVEL_W-1:0] ceil_reg;
        logic [pclg_pkg::RATE_W-1:0]  attack_reg;
        logic [pclg_pkg::RATE_W-1:0]  release_reg;
        logic [pclg_pkg::LEVEL_W-1:0] held;
        gain_result_t                 expected_q[$];
        int                           failures;

        function new();
            thr_reg = pclg_pkg::LEVEL_W'(UNITY);
            ratio_reg = pclg_pkg::RATIO_ONE;
            ceil_reg = pclg_pkg::LEVEL_W'(UNITY);
            attack_reg = '0;
            release_reg = '0;
            held = pclg_pkg::LEVEL_W'(UNITY);
            failures = 0;
        endfunction

        function void write_reg(pclg_pkg::cfg_index_t idx,
                                logic [pclg_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                pclg_pkg::CFG_THRESHOLD: thr_reg = val[pclg_pkg::LEVEL_W-1:0];
                pclg_pkg::CFG_RATIO:     ratio_reg = val[pclg_pkg::LEVEL_W-1:0];
                pclg_pkg::CFG_CEILING:   ceil_reg = val[pclg_pkg::LEVEL_W-1:0];
                pclg_pkg::CFG_ATTACK:    attack_reg = val[pclg_pkg::RATE_W-1:0];
                pclg_pkg::CFG_RELEASE:   release_reg = val[pclg_pkg::RATE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] limit_unity(logic [63:0] v);
            return (v > UNITY) ? UNITY : v;
        endfunction

        function logic [63:0] curve_gain(logic [63:0] level);
            logic [63:0] thr;
            logic [63:0] ceil_lvl;
            logic [63:0] ratio;
            logic [63:0] allowed;
            thr = limit_unity(64'(thr_reg));
            ceil_lvl = limit_unity(64'(ceil_reg));
            ratio = (ratio_reg < pclg_pkg::RATIO_ONE) ? 64'(pclg_pkg::RATIO_ONE)
                                                      : 64'(ratio_reg);
            if (ceil_lvl < thr) begin
                ceil_lvl = thr;
            end
            if (level == 0 || level <= thr) begin
                return UNITY;
            end
            allowed = thr + (((level - thr) << 8) / ratio);
            if (allowed > ceil_lvl) begin
                allowed = ceil_lvl;
            end
            return limit_unity((allowed << pclg_pkg::LEVEL_FRAC_BITS) / level);
        endfunction

        function void note_word(logic [39:0] word);
            logic [63:0]  level;
            logic [63:0]  dt;
            logic [63:0]  tgt;
            logic [63:0]  g;
            logic [63:0]  delta;
            gain_result_t res;
            level = 64'(word[pclg_pkg::LEVEL_W-1:0]);
            dt = 64'(word[pclg_pkg::LEVEL_W +: pclg_pkg::STEP_W]);
            tgt = curve_gain(level);
            g = 64'(held);
            if (dt != 0) begin
                if (g > tgt) begin
                    delta = (64'(attack_reg) * dt) >> pclg_pkg::STEP_FRAC_BITS;
                    g = (delta >= g - tgt) ? tgt : g - delta;
                end else if (g < tgt) begin
                    delta = (64'(release_reg) * dt) >> pclg_pkg::STEP_FRAC_BITS;
                    g = (delta >= tgt - g) ? tgt : g + delta;
                end
                held = pclg_pkg::LEVEL_W'(limit_unity(g));
            end
            res.gain = held;
            res.target = tgt[pclg_pkg::LEVEL_W-1:0];
            expected_q.push_back(res);
        endfunction

        task report(string what, logic [31:0] exp_val, logic [31:0] got_val);
            if (failures < MAX_PRINTS) begin
                $display("MISMATCH %s: expected %0d, got %0d", what, exp_val, got_val);
            end
            failures++;
        endtask

        task check_word(logic [31:0] word);
            gain_result_t exp_res;
            gain_result_t got_res;
            got_res = word;
            if (expected_q.size() == 0) begin
                report("unexpected result word", 0, word);
            end else begin
                exp_res = expected_q.pop_front();
                if (got_res.gain !== exp_res.gain) begin
                    report("current_gain", exp_res.gain, got_res.gain);
                end
                if (got_res.target !== exp_res.target) begin
                    report("target_gain", exp_res.target, got_res.target);
                end
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [39:0]                     s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [31:0]                     m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pclg_pkg::CFG_IDX_W-1:0]  cfg_index = pclg_pkg::CFG_THRESHOLD;
    logic [pclg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    gain_scoreboard sb = new();
    int             cycle_count = 0;
    int             burst_left = 0;
    int             ready_hold = 0;
    int             ready_mode = 0;
    int             ready_phase = 0;
    logic [15:0]    phase_thr;

    peak_compressor_limiter_gain_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(pclg_pkg::cfg_index_t'(cfg_index), cfg_data);
            end
            if (s_tvalid && s_tready) begin
                sb.note_word(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_word(m_tdata);
            end
        end
    end

    always @(negedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(8, 200);
        end
        ready_hold = ready_hold - 1;
        ready_phase = ready_phase + 1;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (ready_phase % 6 == 0);
        endcase
    end

    task write_reg(pclg_pkg::cfg_index_t idx, logic [pclg_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task set_config(logic [15:0] thr, logic [15:0] ratio, logic [15:0] ceil_lvl,
                    logic [30:0] att, logic [30:0] rel);
        drain();
        write_reg(pclg_pkg::CFG_THRESHOLD, pclg_pkg::CFG_DATA_W'(thr));
        write_reg(pclg_pkg::CFG_RATIO, pclg_pkg::CFG_DATA_W'(ratio));
        write_reg(pclg_pkg::CFG_CEILING, pclg_pkg::CFG_DATA_W'(ceil_lvl));
        write_reg(pclg_pkg::CFG_ATTACK, pclg_pkg::CFG_DATA_W'(att));
        write_reg(pclg_pkg::CFG_RELEASE, pclg_pkg::CFG_DATA_W'(rel));
        @(negedge aclk);
        cfg_valid = 1'b0;
        phase_thr = thr;
        burst_left = 0;
    endtask

    task send_word(logic [15:0] level, logic [19:0] dt);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 30);
            gap = $urandom_range(1, 12);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        burst_left = burst_left - 1;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = {4'b0000, dt, level};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function logic [30:0] pick_rate();
        int k;
        k = $urandom_range(1, 31);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom_range(0, 1 << 16));
            3: return 31'($urandom & ((32'd1 << k) - 1));
            default: return 31'((32'd1 << $urandom_range(12, 24)) + $urandom_range(0, 4095));
        endcase
    endfunction

    function logic [15:0] pick_level_cfg();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function logic [15:0] pick_ratio();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd255;
            2: return 16'd256;
            3: return 16'hFFFF;
            4: return 16'($urandom);
            default: return 16'($urandom_range(256, 4096));
        endcase
    endfunction

    function logic [15:0] pick_level();
        int t;
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: begin
                t = int'(phase_thr) + int'($urandom_range(0, 64)) - 32;
                if (t < 0) t = 0;
                if (t > 65535) t = 65535;
                return 16'(t);
            end
            3, 4: return 16'($urandom_range(0, 32768));
            default: return 16'($urandom);
        endcase
    endfunction

    function logic [19:0] pick_step();
        int k;
        k = $urandom_range(1, 20);
        case ($urandom_range(0, 9))
            0: return 20'd0;
            1: return 20'hFFFFF;
            default: return 20'($urandom & ((32'd1 << k) - 1));
        endcase
    endfunction

    initial begin
        logic [15:0] thr;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Reset defaults: unity knee and ceiling, zero rates, so the gain never moves.
        send_word(16'd0, 20'd0);
        send_word(16'hFFFF, 20'hFFFFF);
        send_word(16'd32768, 20'd1);
        send_word(16'd32769, 20'd1);

        set_config(16'd16384, 16'd1024, 16'd24576, 31'h7FFF_FFFF, 31'd32768);
        send_word(16'hFFFF, 20'hFFFFF);
        send_word(16'd16384, 20'd1);
        send_word(16'd16385, 20'hFFFFF);
        send_word(16'd0, 20'd524288);
        send_word(16'd20000, 20'd0);
        send_word(16'd40000, 20'd0);
        send_word(16'd16384, 20'hFFFFF);

        // Threshold above one, ceiling below threshold, ratio below one.
        set_config(16'hFFFF, 16'd0, 16'd0, 31'd0, 31'h7FFF_FFFF);
        send_word(16'hFFFF, 20'hFFFFF);
        send_word(16'd32769, 20'd5);
        send_word(16'd1, 20'd1);
        send_word(16'd0, 20'hFFFFF);

        set_config(16'd0, 16'd255, 16'hFFFF, 31'd1, 31'd1);
        send_word(16'd1, 20'hFFFFF);
        send_word(16'hFFFF, 20'hFFFFF);
        send_word(16'd32768, 20'd1);

        set_config(16'd8192, 16'hFFFF, 16'd12000, 31'd300000, 31'd1000);
        send_word(16'd32768, 20'd1000);
        send_word(16'd65535, 20'd77777);
        send_word(16'd8193, 20'd1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            thr = pick_level_cfg();
            set_config(thr, pick_ratio(),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, thr)) : pick_level_cfg(),
                       pick_rate(), pick_rate());
            for (int i = 0; i < PHASE_WORDS; i++) begin
                send_word(pick_level(), pick_step());
            end
        end

        drain();
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== peak_compressor_limiter_gain_unit.f =====
hdl/pclg_pkg.sv
hdl/pclg_ctrl.sv
hdl/pclg_dp.sv
hdl/peak_compressor_limiter_gain_unit.sv
tb/tb.sv
